FILE: hw/rtl/vkd_pkg.sv
// ----------------------------------------------------------------------------
// vkd_pkg: shared types and constants of the vertex key dedup indexer
// Table geometry, queue geometry, register indexes and the words passed
// between the front, the queue and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

package vkd_pkg;

    // field widths
    localparam int IDX_BITS     = 16;
    localparam int VTX_BITS     = 10;
    localparam int CNT_BITS     = 11;
    localparam int MAX_VERTICES = 1024;

    // hash table: twice the vertex limit so a probe run always ends on a free slot
    localparam int TBL_BITS   = 11;
    localparam int EPOCH_BITS = 8;

    // queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = 1;
    localparam int Q_CNT_BITS = 2;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HAS_POSITION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HAS_NORMAL   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HAS_TEXCOORD = 2'd2;

    typedef struct packed {
        logic has_position;
        logic has_normal;
        logic has_texcoord;
    } t_cfg;

    // one corner as queued for the probe engine
    typedef struct packed {
        logic                mesh_start;
        logic [IDX_BITS-1:0] position_index;
        logic [IDX_BITS-1:0] normal_index;
        logic [IDX_BITS-1:0] texcoord_index;
        logic [TBL_BITS-1:0] hash;
    } t_item;

    typedef struct packed {
        logic [VTX_BITS-1:0] vertex_index;
        logic                is_new;
        logic                fetch_position;
        logic                fetch_normal;
        logic                fetch_texcoord;
        logic [IDX_BITS-1:0] src_position;
        logic [IDX_BITS-1:0] src_normal;
        logic [IDX_BITS-1:0] src_texcoord;
        logic                table_full;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/vkd_front.sv
// ----------------------------------------------------------------------------
// vkd_front: input side of the dedup indexer
// Takes corners from the input channel, hashes the triple to a table slot
// and pushes the word into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module vkd_front (
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_mesh_start,
    input  wire logic [vkd_pkg::IDX_BITS-1:0]  i_position_index,
    input  wire logic [vkd_pkg::IDX_BITS-1:0]  i_normal_index,
    input  wire logic [vkd_pkg::IDX_BITS-1:0]  i_texcoord_index,
    input  wire logic                          i_q_full,
    input  wire logic                          i_sweep,
    output logic                               o_push,
    output vkd_pkg::t_item                     o_item
);

    logic [vkd_pkg::IDX_BITS-1:0] mix;

    // mix the three indexes: byte swap and nibble rotate spread runs of indexes
    always_comb begin
        mix = i_position_index
            ^ {i_normal_index[7:0], i_normal_index[15:8]}
            ^ {i_texcoord_index[3:0], i_texcoord_index[15:4]};
    end

    // fold 16 bits down to a table slot
    always_comb begin
        o_item.mesh_start     = i_mesh_start;
        o_item.position_index = i_position_index;
        o_item.normal_index   = i_normal_index;
        o_item.texcoord_index = i_texcoord_index;
        o_item.hash           = mix[vkd_pkg::TBL_BITS-1:0]
                              ^ {mix[vkd_pkg::IDX_BITS-1:vkd_pkg::TBL_BITS],
                                 (2*vkd_pkg::TBL_BITS-vkd_pkg::IDX_BITS)'(0)};
    end

    // no words taken while the table is being swept
    assign o_ready = !i_q_full && !i_sweep;
    assign o_push  = i_valid && o_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/vkd_queue.sv
// ----------------------------------------------------------------------------
// vkd_queue: short FIFO between the front and the probe engine
// Two entries of registers, so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module vkd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire vkd_pkg::t_item i_item,
    input  wire logic           i_pop,
    output vkd_pkg::t_item      o_item,
    output logic                o_full,
    output logic                o_nempty
);

    vkd_pkg::t_item                  r_mem [vkd_pkg::Q_DEPTH];
    logic [vkd_pkg::Q_PTR_BITS-1:0]  r_wp;
    logic [vkd_pkg::Q_PTR_BITS-1:0]  r_rp;
    logic [vkd_pkg::Q_CNT_BITS-1:0]  r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + vkd_pkg::Q_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + vkd_pkg::Q_PTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + vkd_pkg::Q_CNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - vkd_pkg::Q_CNT_BITS'(1);
            end
        end
    end

    assign o_item   = r_mem[r_rp];
    assign o_full   = (r_cnt == vkd_pkg::Q_CNT_BITS'(vkd_pkg::Q_DEPTH));
    assign o_nempty = (r_cnt != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/vkd_probe.sv
// ----------------------------------------------------------------------------
// vkd_probe: back end of the dedup indexer
// Linear-probe lookup in a hash table held in one memory, insertion of new
// triples, epoch marks for mesh clears, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vkd_probe (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire vkd_pkg::t_cfg  i_cfg,
    input  wire vkd_pkg::t_item i_item,
    input  wire logic           i_item_valid,
    output logic                o_pop,
    output logic                o_sweep,
    output vkd_pkg::t_result    o_result,
    output logic                o_out_valid,
    input  wire logic           i_out_ready
);

    typedef struct packed {
        logic [vkd_pkg::EPOCH_BITS-1:0] epoch;
        logic [vkd_pkg::IDX_BITS-1:0]   position_index;
        logic [vkd_pkg::IDX_BITS-1:0]   normal_index;
        logic [vkd_pkg::IDX_BITS-1:0]   texcoord_index;
        logic [vkd_pkg::VTX_BITS-1:0]   vertex;
    } t_entry;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_PROBE,
        S_CHECK
    } t_state;

    localparam int TBL_DEPTH = 1 << vkd_pkg::TBL_BITS;

    t_entry                          r_mem [TBL_DEPTH];
    t_entry                          r_rd;

    t_state                          r_state, n_state;
    logic [vkd_pkg::TBL_BITS-1:0]    r_slot, n_slot;
    logic [vkd_pkg::EPOCH_BITS-1:0]  r_epoch, n_epoch;
    logic [vkd_pkg::CNT_BITS-1:0]    r_next, n_next;
    logic                            r_pend, n_pend;
    vkd_pkg::t_item                  r_item, n_item;
    vkd_pkg::t_result                r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    logic                            mem_we;
    t_entry                          mem_wdata;
    logic                            live;
    logic                            match;
    logic                            full;
    logic                            proceed;

    // table memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_slot] <= mem_wdata;
        end
        if (r_state == S_PROBE) begin
            r_rd <= r_mem[r_slot];
        end
    end

    // entry belongs to the current mesh when its epoch mark matches
    assign live  = (r_rd.epoch == r_epoch);
    assign match = (r_rd.position_index == r_item.position_index)
                && (r_rd.normal_index   == r_item.normal_index)
                && (r_rd.texcoord_index == r_item.texcoord_index);
    assign full    = (r_next == vkd_pkg::CNT_BITS'(vkd_pkg::MAX_VERTICES));
    assign proceed = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_epoch     = r_epoch;
        n_next      = r_next;
        n_pend      = r_pend;
        n_item      = r_item;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        mem_wdata   = '0;
        o_pop       = 1'b0;

        case (r_state)
            // write epoch zero (never live) into every slot
            S_SWEEP: begin
                mem_we = 1'b1;
                if (r_slot == '1) begin
                    n_epoch = vkd_pkg::EPOCH_BITS'(1);
                    if (r_pend) begin
                        n_pend  = 1'b0;
                        n_slot  = r_item.hash;
                        n_state = S_PROBE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_slot = r_slot + vkd_pkg::TBL_BITS'(1);
                end
            end

            // take a word from the queue; a mesh start opens a new epoch
            S_IDLE: begin
                if (i_item_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_item;
                    n_slot  = i_item.hash;
                    n_state = S_PROBE;
                    if (i_item.mesh_start) begin
                        n_next = '0;
                        if (r_epoch == '1) begin
                            n_pend  = 1'b1;
                            n_slot  = '0;
                            n_state = S_SWEEP;
                        end else begin
                            n_epoch = r_epoch + vkd_pkg::EPOCH_BITS'(1);
                        end
                    end
                end
            end

            // memory read in flight
            S_PROBE: begin
                n_state = S_CHECK;
            end

            // hit, step to next slot, or miss at a free slot
            S_CHECK: begin
                if (live && !match) begin
                    n_slot  = r_slot + vkd_pkg::TBL_BITS'(1);
                    n_state = S_PROBE;
                end else if (proceed) begin
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                    n_out.src_position   = r_item.position_index;
                    n_out.src_normal     = r_item.normal_index;
                    n_out.src_texcoord   = r_item.texcoord_index;
                    n_out.is_new         = 1'b0;
                    n_out.table_full     = 1'b0;
                    n_out.vertex_index   = r_rd.vertex;
                    if (!live) begin
                        if (full) begin
                            n_out.table_full   = 1'b1;
                            n_out.vertex_index = '0;
                        end else begin
                            n_out.is_new             = 1'b1;
                            n_out.vertex_index       = r_next[vkd_pkg::VTX_BITS-1:0];
                            mem_we                   = 1'b1;
                            mem_wdata.epoch          = r_epoch;
                            mem_wdata.position_index = r_item.position_index;
                            mem_wdata.normal_index   = r_item.normal_index;
                            mem_wdata.texcoord_index = r_item.texcoord_index;
                            mem_wdata.vertex         = r_next[vkd_pkg::VTX_BITS-1:0];
                            n_next = r_next + vkd_pkg::CNT_BITS'(1);
                        end
                    end
                    n_out.fetch_position = n_out.is_new && i_cfg.has_position;
                    n_out.fetch_normal   = n_out.is_new && i_cfg.has_normal;
                    n_out.fetch_texcoord = n_out.is_new && i_cfg.has_texcoord;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_slot      <= '0;
            r_epoch     <= vkd_pkg::EPOCH_BITS'(1);
            r_next      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_epoch     <= n_epoch;
            r_next      <= n_next;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_sweep     = (r_state == S_SWEEP);
    assign o_result    = r_out;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_key_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_key_dedup_indexer: vertex deduplication index buffer
// Each corner (position, normal, texcoord index) in gives one word out with
// the vertex index found or assigned, the new-vertex fetch flags and the
// echoed source indexes.
// ----------------------------------------------------------------------------
// Usage:
//   Input words enter on i_valid/o_ready, result words leave on
//   o_valid/i_ready, one result per corner, in input order. Config registers
//   (has_position, has_normal, has_texcoord) are written through i_cfg_we,
//   i_cfg_idx and i_cfg_data while the block is idle.
//   A hashed table of 2048 slots in one memory is searched by linear probing;
//   each probe is one memory read (S_PROBE) and one compare (S_CHECK). A
//   corner is popped from the queue in S_IDLE, probed until a hit or a free
//   slot, and its result goes into the output register once that is free.
//   A mesh start bumps an epoch mark, so clearing is free, except that once
//   every 255 mesh starts the epoch wraps and a sweep rewrites the table
//   before that corner proceeds.
//   After reset the table is swept with o_ready low.
//   A two-word queue sits in front of the probe engine; when the receiver
//   stalls, the output register holds its word and the queue fills, then
//   o_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_key_dedup_indexer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [vkd_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic                              i_cfg_data,
    // input channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_mesh_start,
    input  wire logic [vkd_pkg::IDX_BITS-1:0]      i_position_index,
    input  wire logic [vkd_pkg::IDX_BITS-1:0]      i_normal_index,
    input  wire logic [vkd_pkg::IDX_BITS-1:0]      i_texcoord_index,
    // output channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [vkd_pkg::VTX_BITS-1:0]           o_vertex_index,
    output logic                                   o_is_new,
    output logic                                   o_fetch_position,
    output logic                                   o_fetch_normal,
    output logic                                   o_fetch_texcoord,
    output logic [vkd_pkg::IDX_BITS-1:0]           o_src_position,
    output logic [vkd_pkg::IDX_BITS-1:0]           o_src_normal,
    output logic [vkd_pkg::IDX_BITS-1:0]           o_src_texcoord,
    output logic                                   o_table_full
);

    vkd_pkg::t_cfg    r_cfg;
    vkd_pkg::t_item   push_item;
    vkd_pkg::t_item   q_item;
    vkd_pkg::t_result result;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_nempty;
    logic             sweep;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.has_position <= 1'b1;
            r_cfg.has_normal   <= 1'b1;
            r_cfg.has_texcoord <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vkd_pkg::CFG_HAS_POSITION: r_cfg.has_position <= i_cfg_data;
                vkd_pkg::CFG_HAS_NORMAL:   r_cfg.has_normal   <= i_cfg_data;
                vkd_pkg::CFG_HAS_TEXCOORD: r_cfg.has_texcoord <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vkd_front u_front (
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mesh_start     (i_mesh_start),
        .i_position_index (i_position_index),
        .i_normal_index   (i_normal_index),
        .i_texcoord_index (i_texcoord_index),
        .i_q_full         (q_full),
        .i_sweep          (sweep),
        .o_push           (push),
        .o_item           (push_item)
    );

    vkd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (q_item),
        .o_full   (q_full),
        .o_nempty (q_nempty)
    );

    vkd_probe u_probe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (q_item),
        .i_item_valid (q_nempty),
        .o_pop        (pop),
        .o_sweep      (sweep),
        .o_result     (result),
        .o_out_valid  (o_valid),
        .i_out_ready  (i_ready)
    );

    // result word fields
    assign o_vertex_index   = result.vertex_index;
    assign o_is_new         = result.is_new;
    assign o_fetch_position = result.fetch_position;
    assign o_fetch_normal   = result.fetch_normal;
    assign o_fetch_texcoord = result.fetch_texcoord;
    assign o_src_position   = result.src_position;
    assign o_src_normal     = result.src_normal;
    assign o_src_texcoord   = result.src_texcoord;
    assign o_table_full     = result.table_full;

endmodule

`default_nettype wire

FILE: test/vertex_key_dedup_indexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vertex_key_dedup_indexer_tb: self-checking bench for the vertex dedup indexer
// Streams corner words through the valid/ready input with bursty gaps and
// collects result words under a stalling receiver. A table model predicts
// each result word, which is checked field by field in order. Stimulus:
// directed corners, one mesh that fills the table and overflows it, then
// random meshes with reuse, near misses and stray mesh starts under
// several flag settings.
// ----------------------------------------------------------------------------

module vertex_key_dedup_indexer_tb;

    localparam int          SETTLE_CYCLES  = 8;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          LONG_HOLD      = 300;
    localparam int          HOLD_SPACING   = 600;
    localparam int          RANDOM_PHASES  = 4;
    localparam int          PHASE_CORNERS  = 60;
    localparam int          PHASE_STARTS   = 63;
    localparam int          OVERFLOW_TRIES = 16;
    localparam logic [vkd_pkg::CFG_IDX_BITS-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam logic [vkd_pkg::IDX_BITS-1:0]     IDX_MAX        = '1;

    typedef logic [3*vkd_pkg::IDX_BITS-1:0] t_triple;

    typedef struct packed {
        logic    mesh_start;
        t_triple triple;
    } t_corner;

    // DUT ports
    logic                             i_clk            = 1'b0;
    logic                             i_rst_n          = 1'b0;
    logic                             i_cfg_we         = 1'b0;
    logic [vkd_pkg::CFG_IDX_BITS-1:0] i_cfg_idx        = vkd_pkg::CFG_HAS_POSITION;
    logic                             i_cfg_data       = 1'b0;
    logic                             i_valid          = 1'b0;
    logic                             o_ready;
    logic                             i_mesh_start     = 1'b0;
    logic [vkd_pkg::IDX_BITS-1:0]     i_position_index = '0;
    logic [vkd_pkg::IDX_BITS-1:0]     i_normal_index   = '0;
    logic [vkd_pkg::IDX_BITS-1:0]     i_texcoord_index = '0;
    logic                             o_valid;
    logic                             i_ready          = 1'b0;
    logic [vkd_pkg::VTX_BITS-1:0]     o_vertex_index;
    logic                             o_is_new;
    logic                             o_fetch_position;
    logic                             o_fetch_normal;
    logic                             o_fetch_texcoord;
    logic [vkd_pkg::IDX_BITS-1:0]     o_src_position;
    logic [vkd_pkg::IDX_BITS-1:0]     o_src_normal;
    logic [vkd_pkg::IDX_BITS-1:0]     o_src_texcoord;
    logic                             o_table_full;

    // bench state
    t_corner          pending_corners[$];
    vkd_pkg::t_result expected_results[$];
    vkd_pkg::t_cfg    flags_now = '{has_position: 1'b1, has_normal: 1'b1,
                                    has_texcoord: 1'b1};
    logic [vkd_pkg::VTX_BITS-1:0] vertex_of_triple[t_triple];
    int unsigned  vertices_assigned = 0;
    int unsigned  corners_sent      = 0;
    int unsigned  mesh_starts_sent  = 0;
    int unsigned  results_seen      = 0;
    int unsigned  cycle_count       = 0;
    t_triple      last_triple       = '0;
    bit           failed            = 1'b0;

    vertex_key_dedup_indexer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mesh_start     (i_mesh_start),
        .i_position_index (i_position_index),
        .i_normal_index   (i_normal_index),
        .i_texcoord_index (i_texcoord_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_vertex_index   (o_vertex_index),
        .o_is_new         (o_is_new),
        .o_fetch_position (o_fetch_position),
        .o_fetch_normal   (o_fetch_normal),
        .o_fetch_texcoord (o_fetch_texcoord),
        .o_src_position   (o_src_position),
        .o_src_normal     (o_src_normal),
        .o_src_texcoord   (o_src_texcoord),
        .o_table_full     (o_table_full)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Dedup table model: maps a triple to its vertex, counts assigned vertices
    function automatic vkd_pkg::t_result index_corner(t_corner c);
        vkd_pkg::t_result r;
        r = '0;
        if (c.mesh_start) begin
            vertex_of_triple.delete();
            vertices_assigned = 0;
        end
        r.src_position = c.triple[3*vkd_pkg::IDX_BITS-1:2*vkd_pkg::IDX_BITS];
        r.src_normal   = c.triple[2*vkd_pkg::IDX_BITS-1:vkd_pkg::IDX_BITS];
        r.src_texcoord = c.triple[vkd_pkg::IDX_BITS-1:0];
        if (vertex_of_triple.exists(c.triple)) begin
            r.vertex_index = vertex_of_triple[c.triple];
        end else if (vertices_assigned < vkd_pkg::MAX_VERTICES) begin
            r.vertex_index               = vertices_assigned[vkd_pkg::VTX_BITS-1:0];
            vertex_of_triple[c.triple]   = r.vertex_index;
            vertices_assigned++;
            r.is_new         = 1'b1;
            r.fetch_position = flags_now.has_position;
            r.fetch_normal   = flags_now.has_normal;
            r.fetch_texcoord = flags_now.has_texcoord;
        end else begin
            // miss with no room left: nothing stored, index reads zero
            r.table_full = 1'b1;
        end
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        logic accepted;
        accepted = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (accepted) begin
                expected_results.push_back(index_corner(pending_corners.pop_front()));
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            // payload only moves once the current word is gone
            if (!i_valid || accepted) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_corners.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid          <= 1'b1;
                    i_mesh_start     <= pending_corners[0].mesh_start;
                    i_position_index <= pending_corners[0].triple[3*vkd_pkg::IDX_BITS-1:
                                                                  2*vkd_pkg::IDX_BITS];
                    i_normal_index   <= pending_corners[0].triple[2*vkd_pkg::IDX_BITS-1:
                                                                  vkd_pkg::IDX_BITS];
                    i_texcoord_index <= pending_corners[0].triple[vkd_pkg::IDX_BITS-1:0];
                end
            end
        end
    end

    // Receiver: stall pattern re-drawn whenever mode_cycles[5:0] wraps to zero, plus long hold-offs
    int unsigned stall_mode   = 0;
    int unsigned mode_cycles  = 0;
    int unsigned hold_left    = 0;
    int unsigned next_hold_at = 40;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            mode_cycles++;
            if (mode_cycles[5:0] == 6'd0) begin
                stall_mode = $urandom_range(0, 3);
            end
            if (hold_left == 0 && results_seen >= next_hold_at) begin
                hold_left     = LONG_HOLD;
                next_hold_at += HOLD_SPACING;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (mode_cycles[2:0] < 3'd5);
                endcase
            end
        end
    end

    task automatic check_field(string name, logic [vkd_pkg::IDX_BITS-1:0] want,
                               logic [vkd_pkg::IDX_BITS-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    // Monitor: each result word against the oldest prediction
    always @(posedge i_clk) begin
        vkd_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: result word with nothing expected, vertex_index %0h",
                         $time, o_vertex_index);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                check_field("vertex_index",
                            vkd_pkg::IDX_BITS'(want.vertex_index),
                            vkd_pkg::IDX_BITS'(o_vertex_index));
                check_field("is_new",
                            vkd_pkg::IDX_BITS'(want.is_new),
                            vkd_pkg::IDX_BITS'(o_is_new));
                check_field("fetch_position",
                            vkd_pkg::IDX_BITS'(want.fetch_position),
                            vkd_pkg::IDX_BITS'(o_fetch_position));
                check_field("fetch_normal",
                            vkd_pkg::IDX_BITS'(want.fetch_normal),
                            vkd_pkg::IDX_BITS'(o_fetch_normal));
                check_field("fetch_texcoord",
                            vkd_pkg::IDX_BITS'(want.fetch_texcoord),
                            vkd_pkg::IDX_BITS'(o_fetch_texcoord));
                check_field("src_position",   want.src_position,   o_src_position);
                check_field("src_normal",     want.src_normal,     o_src_normal);
                check_field("src_texcoord",   want.src_texcoord,   o_src_texcoord);
                check_field("table_full",
                            vkd_pkg::IDX_BITS'(want.table_full),
                            vkd_pkg::IDX_BITS'(o_table_full));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: no progress, %0d words still expected", $time,
                     expected_results.size());
            $display("vertex_key_dedup_indexer verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_corner(logic mesh_start, t_triple triple);
        pending_corners.push_back('{mesh_start: mesh_start, triple: triple});
        corners_sent++;
        if (mesh_start) begin
            mesh_starts_sent++;
        end
        last_triple = triple;
    endtask

    function automatic logic [vkd_pkg::IDX_BITS-1:0] pick_index();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return IDX_MAX;
        if (roll == 2) return vkd_pkg::IDX_BITS'($urandom_range(0, 7));
        return vkd_pkg::IDX_BITS'($urandom);
    endfunction

    function automatic t_triple fresh_triple();
        t_triple t;
        t[3*vkd_pkg::IDX_BITS-1:2*vkd_pkg::IDX_BITS] = vkd_pkg::IDX_BITS'($urandom);
        t[2*vkd_pkg::IDX_BITS-1:vkd_pkg::IDX_BITS]   = vkd_pkg::IDX_BITS'($urandom);
        t[vkd_pkg::IDX_BITS-1:0]                     = vkd_pkg::IDX_BITS'($urandom);
        return t;
    endfunction

    // Wait out everything in flight, then let the block settle
    task automatic drain();
        while (pending_corners.size() != 0 || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_flags(logic pos, logic nrm, logic tex, bit poke_unused);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= vkd_pkg::CFG_HAS_POSITION;
        i_cfg_data <= pos;
        @(posedge i_clk);
        i_cfg_idx  <= vkd_pkg::CFG_HAS_NORMAL;
        i_cfg_data <= nrm;
        @(posedge i_clk);
        i_cfg_idx  <= vkd_pkg::CFG_HAS_TEXCOORD;
        i_cfg_data <= tex;
        if (poke_unused) begin
            // out-of-range index must leave every flag alone
            @(posedge i_clk);
            i_cfg_idx  <= CFG_IDX_UNUSED;
            i_cfg_data <= ~tex;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        flags_now.has_position = pos;
        flags_now.has_normal   = nrm;
        flags_now.has_texcoord = tex;
    endtask

    // One mesh: reuse for hits, one-bit near misses, extremes, fresh triples
    task automatic queue_random_mesh(int unsigned len);
        t_triple     seen_here[$];
        t_triple     key;
        int unsigned roll;
        logic        start;
        for (int unsigned k = 0; k < len; k++) begin
            roll  = $urandom_range(0, 99);
            start = (k == 0) || ($urandom_range(0, 99) < 3);
            if (k == 0 && roll < 20) begin
                key = last_triple;  // repeat across a mesh start: must miss
            end else if (seen_here.size() != 0 && roll < 45) begin
                key = seen_here[$urandom_range(0, seen_here.size() - 1)];
            end else if (seen_here.size() != 0 && roll < 60) begin
                key = seen_here[$urandom_range(0, seen_here.size() - 1)];
                key[$urandom_range(0, 3*vkd_pkg::IDX_BITS - 1)] ^= 1'b1;
            end else if (roll < 70) begin
                key = {pick_index(), pick_index(), pick_index()};
            end else begin
                key = fresh_triple();
            end
            push_corner(start, key);
            seen_here.push_back(key);
        end
    endtask

    // Fill one mesh to the vertex limit, then mix misses and hits on a full table
    task automatic queue_overflow_mesh();
        bit      stored[t_triple];
        t_triple stored_list[$];
        t_triple key;
        while (stored_list.size() < vkd_pkg::MAX_VERTICES) begin
            key = (stored_list.size() % 16 == 0) ?
                  {pick_index(), pick_index(), pick_index()} : fresh_triple();
            if (!stored.exists(key)) begin
                push_corner(stored_list.size() == 0, key);
                stored[key] = 1'b1;
                stored_list.push_back(key);
            end
        end
        for (int k = 0; k < OVERFLOW_TRIES; k++) begin
            if (k % 2 == 1) begin
                push_corner(1'b0,
                            stored_list[$urandom_range(0, vkd_pkg::MAX_VERTICES - 1)]);
            end else begin
                do begin
                    key = {pick_index(), pick_index(), pick_index()};
                end while (stored.exists(key));
                push_corner(1'b0, key);
            end
        end
        // a mesh start must empty the full table
        push_corner(1'b1, stored_list[vkd_pkg::MAX_VERTICES - 1]);
        push_corner(1'b0, stored_list[0]);
    endtask

    initial begin
        int unsigned corner_base;
        int unsigned start_base;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners under the reset flags
        push_corner(1'b1, {16'h0000, 16'h0000, 16'h0000});
        push_corner(1'b0, {IDX_MAX, IDX_MAX, IDX_MAX});
        push_corner(1'b0, {16'h0000, 16'h0000, 16'h0000});
        push_corner(1'b0, {IDX_MAX, IDX_MAX, IDX_MAX});
        push_corner(1'b0, {IDX_MAX, 16'h0000, 16'h0000});
        push_corner(1'b0, {16'h0000, IDX_MAX, 16'h0000});
        push_corner(1'b0, {16'h0000, 16'h0000, IDX_MAX});
        push_corner(1'b0, {16'h0000, 16'h0000, 16'h0001});
        push_corner(1'b0, {16'h8000, 16'h0000, 16'h0000});
        push_corner(1'b0, {16'h0000, 16'h8000, 16'h0000});
        push_corner(1'b0, {IDX_MAX, 16'h0000, 16'h0000});
        push_corner(1'b0, {16'h0000, 16'h0000, IDX_MAX});
        push_corner(1'b1, {16'h0000, 16'h0000, 16'h0000});
        push_corner(1'b1, {16'h0000, 16'h0000, 16'h0000});
        push_corner(1'b0, {16'h1234, 16'h5678, 16'h9ABC});
        push_corner(1'b0, {16'h1234, 16'h5678, 16'h9ABC});
        push_corner(1'b0, {16'hEDCB, 16'hA987, 16'h6543});
        push_corner(1'b0, {16'h1234, 16'h5678, 16'h9ABC});
        push_corner(1'b1, {16'hEDCB, 16'hA987, 16'h6543});
        push_corner(1'b0, {16'h5555, 16'hAAAA, 16'h5555});
        push_corner(1'b0, {16'hAAAA, 16'h5555, 16'hAAAA});
        drain();

        write_flags(1'b1, 1'b0, 1'b1, 1'b1);
        queue_overflow_mesh();
        drain();

        // random meshes, several flag settings, enough starts to wrap the epoch
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: write_flags(1'b0, 1'b0, 1'b0, 1'b0);
                1: write_flags(1'b0, 1'b1, 1'b0, 1'b0);
                2: write_flags(1'b1, 1'b1, 1'b1, 1'b0);
                default: write_flags(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     1'($urandom_range(0, 1)), 1'b0);
            endcase
            corner_base = corners_sent;
            start_base  = mesh_starts_sent;
            while (corners_sent - corner_base < PHASE_CORNERS ||
                   mesh_starts_sent - start_base < PHASE_STARTS) begin
                queue_random_mesh(($urandom_range(0, 99) < 85) ?
                                  1 : $urandom_range(2, 5));
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (!failed) begin
            $display("vertex_key_dedup_indexer verification clean");
        end else begin
            $display("vertex_key_dedup_indexer verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/vkd_pkg.sv
hw/rtl/vkd_front.sv
hw/rtl/vkd_queue.sv
hw/rtl/vkd_probe.sv
hw/rtl/vertex_key_dedup_indexer.sv
test/vertex_key_dedup_indexer_tb.sv
